/* src/nnsa_pkg.sv */
// shared types, widths and codes of the nearest-neighbor scale address unit
package nnsa_pkg;

	localparam int COL_W   = 12;
	localparam int DIM_W   = 13;
	localparam int LINE_W  = 15;
	localparam int BPP_W   = 6;
	localparam int PB_W    = 3;
	localparam int OFF_W   = 26;
	localparam int NUM_W   = 24;
	localparam int DCOL_W  = COL_W + PB_W;
	localparam int ST_W    = 2;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int STEPS   = COL_W;

	localparam int MAX_DIM        = 4096;
	localparam int MAX_LINE_BYTES = 16384;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_DEPTH = 2'd1;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

	typedef enum logic [2:0] {
		REG_SRC_WIDTH  = 3'd0,
		REG_SRC_HEIGHT = 3'd1,
		REG_DST_WIDTH  = 3'd2,
		REG_DST_HEIGHT = 3'd3,
		REG_SRC_LINE   = 3'd4,
		REG_DST_LINE   = 3'd5,
		REG_SRC_BPP    = 3'd6,
		REG_DST_BPP    = 3'd7
	} reg_idx_t;

	// clamped settings as the datapath sees them
	typedef struct packed {
		logic [DIM_W-1:0]  sw;
		logic [DIM_W-1:0]  sh;
		logic [DIM_W-1:0]  dw;
		logic [DIM_W-1:0]  dh;
		logic [LINE_W-1:0] sl;
		logic [LINE_W-1:0] dl;
		logic [PB_W-1:0]   pb;
		logic              depth_mismatch;
	} cfg_t;

	// fields riding alongside the divider
	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [OFF_W-1:0]  dprod;
		logic [DCOL_W-1:0] dcol;
	} side_t;

endpackage

/* src/nnsa_cfg_regs.sv */
// apb register file and clamped settings of the scale address unit
module nnsa_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [nnsa_pkg::ADDR_W-1:0]  paddr,
	input  logic [nnsa_pkg::DATA_W-1:0]  pwdata,
	output logic [nnsa_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output nnsa_pkg::cfg_t               cfg
);
	import nnsa_pkg::*;

	logic [DIM_W-1:0]  src_width_q, src_height_q, dst_width_q, dst_height_q;
	logic [LINE_W-1:0] src_line_q, dst_line_q;
	logic [BPP_W-1:0]  src_bpp_q, dst_bpp_q;
	logic              wr_en;
	reg_idx_t          idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= DIM_W'(1);
			src_height_q <= DIM_W'(1);
			dst_width_q  <= DIM_W'(1);
			dst_height_q <= DIM_W'(1);
			src_line_q   <= LINE_W'(1);
			dst_line_q   <= LINE_W'(1);
			src_bpp_q    <= BPP_W'(8);
			dst_bpp_q    <= BPP_W'(8);
		end else if (wr_en) begin
			unique case (idx)
				REG_SRC_WIDTH:  src_width_q  <= pwdata[DIM_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= pwdata[DIM_W-1:0];
				REG_DST_WIDTH:  dst_width_q  <= pwdata[DIM_W-1:0];
				REG_DST_HEIGHT: dst_height_q <= pwdata[DIM_W-1:0];
				REG_SRC_LINE:   src_line_q   <= pwdata[LINE_W-1:0];
				REG_DST_LINE:   dst_line_q   <= pwdata[LINE_W-1:0];
				REG_SRC_BPP:    src_bpp_q    <= pwdata[BPP_W-1:0];
				REG_DST_BPP:    dst_bpp_q    <= pwdata[BPP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SRC_WIDTH:  prdata = DATA_W'(src_width_q);
			REG_SRC_HEIGHT: prdata = DATA_W'(src_height_q);
			REG_DST_WIDTH:  prdata = DATA_W'(dst_width_q);
			REG_DST_HEIGHT: prdata = DATA_W'(dst_height_q);
			REG_SRC_LINE:   prdata = DATA_W'(src_line_q);
			REG_DST_LINE:   prdata = DATA_W'(dst_line_q);
			REG_SRC_BPP:    prdata = DATA_W'(src_bpp_q);
			REG_DST_BPP:    prdata = DATA_W'(dst_bpp_q);
			default:        prdata = '0;
		endcase
	end

	// oversized dimensions and line lengths clamp to the maximum
	always_comb begin
		cfg.sw = (src_width_q  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : src_width_q;
		cfg.sh = (src_height_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : src_height_q;
		cfg.dw = (dst_width_q  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dst_width_q;
		cfg.dh = (dst_height_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dst_height_q;
		cfg.sl = (src_line_q > LINE_W'(MAX_LINE_BYTES)) ? LINE_W'(MAX_LINE_BYTES)
			: src_line_q;
		cfg.dl = (dst_line_q > LINE_W'(MAX_LINE_BYTES)) ? LINE_W'(MAX_LINE_BYTES)
			: dst_line_q;
		cfg.pb = src_bpp_q[BPP_W-1:3];
		cfg.depth_mismatch = (src_bpp_q != dst_bpp_q);
	end

endmodule

/* src/nnsa_div_pipe.sv */
// pipelined restoring divider, one quotient bit per stage, column and row in parallel
module nnsa_div_pipe (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [nnsa_pkg::NUM_W-1:0]  num_c,
	input  logic [nnsa_pkg::NUM_W-1:0]  num_r,
	input  nnsa_pkg::side_t             side_in,
	input  logic [nnsa_pkg::DIM_W-1:0]  div_c,
	input  logic [nnsa_pkg::DIM_W-1:0]  div_r,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [nnsa_pkg::COL_W-1:0]  quot_c,
	output logic [nnsa_pkg::COL_W-1:0]  quot_r,
	output nnsa_pkg::side_t             side_out
);
	import nnsa_pkg::*;

	logic [STEPS-1:0] vld_s;
	logic [STEPS:0]   rdy;
	logic [NUM_W-1:0] rem_c_s [STEPS];
	logic [NUM_W-1:0] rem_r_s [STEPS];
	logic [COL_W-1:0] q_c_s   [STEPS];
	logic [COL_W-1:0] q_r_s   [STEPS];
	side_t            side_s  [STEPS];

	logic [NUM_W-1:0] rem_c_nx [STEPS];
	logic [NUM_W-1:0] rem_r_nx [STEPS];
	logic [COL_W-1:0] q_c_nx   [STEPS];
	logic [COL_W-1:0] q_r_nx   [STEPS];
	logic             vld_in   [STEPS];
	side_t            side_nx  [STEPS];

	// a stage takes new data when it is empty or its successor moves
	always_comb begin
		rdy[STEPS] = out_ready;
		for (int k = STEPS - 1; k >= 0; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	always_comb begin
		for (int k = 0; k < STEPS; k++) begin
			logic [NUM_W-1:0] rc, rr, dc, dr;
			logic [COL_W-1:0] qc, qr;
			rc = (k == 0) ? num_c : rem_c_s[(k == 0) ? 0 : k - 1];
			rr = (k == 0) ? num_r : rem_r_s[(k == 0) ? 0 : k - 1];
			qc = (k == 0) ? '0 : q_c_s[(k == 0) ? 0 : k - 1];
			qr = (k == 0) ? '0 : q_r_s[(k == 0) ? 0 : k - 1];
			dc = NUM_W'(div_c) << (STEPS - 1 - k);
			dr = NUM_W'(div_r) << (STEPS - 1 - k);
			if (rc >= dc) begin
				rc = rc - dc;
				qc[STEPS-1-k] = 1'b1;
			end
			if (rr >= dr) begin
				rr = rr - dr;
				qr[STEPS-1-k] = 1'b1;
			end
			rem_c_nx[k] = rc;
			rem_r_nx[k] = rr;
			q_c_nx[k]   = qc;
			q_r_nx[k]   = qr;
			vld_in[k]   = (k == 0) ? in_valid : vld_s[(k == 0) ? 0 : k - 1];
			side_nx[k]  = (k == 0) ? side_in : side_s[(k == 0) ? 0 : k - 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 0; k < STEPS; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= vld_in[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < STEPS; k++) begin
			if (rdy[k] && vld_in[k]) begin
				rem_c_s[k] <= rem_c_nx[k];
				rem_r_s[k] <= rem_r_nx[k];
				q_c_s[k]   <= q_c_nx[k];
				q_r_s[k]   <= q_r_nx[k];
				side_s[k]  <= side_nx[k];
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[STEPS-1];
	assign quot_c    = q_c_s[STEPS-1];
	assign quot_r    = q_r_s[STEPS-1];
	assign side_out  = side_s[STEPS-1];

`ifndef SYNTHESIS
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (&vld_s))
		else $error("divider refuses input while a stage is empty");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quot_c) && $stable(quot_r))
		else $error("stalled quotient changed");

	a_remainder_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (side_out.status == ST_OK) |->
			(rem_c_s[STEPS-1] < NUM_W'(div_c)) && (rem_r_s[STEPS-1] < NUM_W'(div_r)))
		else $error("final remainder not below divisor");
`endif

endmodule

/* src/nearest_neighbor_scale_address_unit.sv */
// top level of the nearest-neighbor scale address unit
//
//  port group        direction  handshake          content
//  in_*  / dest_*    in         in_valid/in_ready  destination column and row
//  out_* / results   out        out_valid/out_ready src/dst offsets, pixel bytes, status
//  apb  (p*)         in/out     psel/penable       eight settings registers
//
// one coordinate accepted per cycle while no output stall backs up to the input
// stages: capture, products, 12 divider stages (one quotient bit each), two offset stages
// each stage has its own valid bit; a stall fills bubbles and holds the rest in place
// reset clears valid bits and loads default settings; no memory, no clearing pass
module nearest_neighbor_scale_address_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [nnsa_pkg::COL_W-1:0]   dest_col,
	input  logic [nnsa_pkg::COL_W-1:0]   dest_row,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [nnsa_pkg::OFF_W-1:0]   src_offset,
	output logic [nnsa_pkg::OFF_W-1:0]   dst_offset,
	output logic [nnsa_pkg::PB_W-1:0]    pixel_bytes,
	output logic [nnsa_pkg::ST_W-1:0]    status,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [nnsa_pkg::ADDR_W-1:0]  paddr,
	input  logic [nnsa_pkg::DATA_W-1:0]  pwdata,
	output logic [nnsa_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import nnsa_pkg::*;

	cfg_t cfg;

	// stage 1: capture and classify
	logic              vld_s1, rdy_s1;
	logic [COL_W-1:0]  col_s1, row_s1;
	logic [ST_W-1:0]   st_s1;
	logic [ST_W-1:0]   st_nx;

	// stage 2: products
	logic              vld_s2, rdy_s2;
	logic [NUM_W-1:0]  ncol_s2, nrow_s2;
	side_t             side_s2;
	logic [NUM_W:0]    ncol_w, nrow_w;
	logic [COL_W+LINE_W-1:0] dprod_w;

	// divider
	logic              div_in_ready, div_out_valid;
	logic [COL_W-1:0]  qc, qr;
	side_t             side_div;

	// stage 15: source products and destination sum
	logic              vld_s15, rdy_s15;
	logic [OFF_W-1:0]  srow_s15, doff_s15;
	logic [DCOL_W-1:0] scol_s15;
	logic [ST_W-1:0]   st_s15;
	logic [PB_W-1:0]   pb_s15;
	logic [COL_W+LINE_W-1:0] srow_w;

	// stage 16: output register
	logic              vld_s16, rdy_s16;
	logic [OFF_W-1:0]  soff_s16, doff_s16;
	logic [PB_W-1:0]   pb_s16;
	logic [ST_W-1:0]   st_s16;

	nnsa_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign rdy_s16 = !vld_s16 || out_ready;
	assign rdy_s15 = !vld_s15 || rdy_s16;
	assign rdy_s2  = !vld_s2 || div_in_ready;
	assign rdy_s1  = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// depth check wins over the range check
	always_comb begin
		if (cfg.depth_mismatch) begin
			st_nx = ST_DEPTH;
		end else if ((DIM_W'(dest_col) >= cfg.dw) || (DIM_W'(dest_row) >= cfg.dh)) begin
			st_nx = ST_RANGE;
		end else begin
			st_nx = ST_OK;
		end
	end

	assign ncol_w  = (NUM_W+1)'(col_s1) * (NUM_W+1)'(cfg.sw);
	assign nrow_w  = (NUM_W+1)'(row_s1) * (NUM_W+1)'(cfg.sh);
	assign dprod_w = (COL_W+LINE_W)'(row_s1) * (COL_W+LINE_W)'(cfg.dl);
	assign srow_w  = (COL_W+LINE_W)'(qr) * (COL_W+LINE_W)'(cfg.sl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s15 <= 1'b0;
			vld_s16 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= in_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s15) begin
				vld_s15 <= div_out_valid;
			end
			if (rdy_s16) begin
				vld_s16 <= vld_s15;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			col_s1 <= dest_col;
			row_s1 <= dest_row;
			st_s1  <= st_nx;
		end
		if (rdy_s2 && vld_s1) begin
			ncol_s2        <= ncol_w[NUM_W-1:0];
			nrow_s2        <= nrow_w[NUM_W-1:0];
			side_s2.status <= st_s1;
			side_s2.dprod  <= dprod_w[OFF_W-1:0];
			side_s2.dcol   <= DCOL_W'(col_s1) * DCOL_W'(cfg.pb);
		end
		if (rdy_s15 && div_out_valid) begin
			srow_s15 <= srow_w[OFF_W-1:0];
			scol_s15 <= DCOL_W'(qc) * DCOL_W'(cfg.pb);
			doff_s15 <= side_div.dprod + OFF_W'(side_div.dcol);
			st_s15   <= side_div.status;
			pb_s15   <= cfg.pb;
		end
		if (rdy_s16 && vld_s15) begin
			st_s16 <= st_s15;
			if (st_s15 == ST_OK) begin
				soff_s16 <= srow_s15 + OFF_W'(scol_s15);
				doff_s16 <= doff_s15;
				pb_s16   <= pb_s15;
			end else begin
				soff_s16 <= '0;
				doff_s16 <= '0;
				pb_s16   <= '0;
			end
		end
	end

	nnsa_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.in_ready  (div_in_ready),
		.num_c     (ncol_s2),
		.num_r     (nrow_s2),
		.side_in   (side_s2),
		.div_c     (cfg.dw),
		.div_r     (cfg.dh),
		.out_valid (div_out_valid),
		.out_ready (rdy_s15),
		.quot_c    (qc),
		.quot_r    (qr),
		.side_out  (side_div)
	);

	assign out_valid   = vld_s16;
	assign src_offset  = soff_s16;
	assign dst_offset  = doff_s16;
	assign pixel_bytes = pb_s16;
	assign status      = st_s16;

`ifndef SYNTHESIS
	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |->
			(src_offset == '0) && (dst_offset == '0) && (pixel_bytes == '0))
		else $error("error result carries nonzero fields");

	a_accept_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> in_ready)
		else $error("input refused with empty first stage");

	a_depth_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status == ST_DEPTH) == cfg.depth_mismatch))
		else $error("depth mismatch status disagrees with settings");
`endif

endmodule

/* tb/scale_address_checker.sv */
`timescale 1ns / 100ps
// transfer monitor, result predictor and scoreboard for the nearest-neighbor scale address unit
module scale_address_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [nnsa_pkg::COL_W-1:0]  dest_col,
	input  logic [nnsa_pkg::COL_W-1:0]  dest_row,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [nnsa_pkg::OFF_W-1:0]  src_offset,
	input  logic [nnsa_pkg::OFF_W-1:0]  dst_offset,
	input  logic [nnsa_pkg::PB_W-1:0]   pixel_bytes,
	input  logic [nnsa_pkg::ST_W-1:0]   status,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [nnsa_pkg::ADDR_W-1:0] paddr,
	input  logic [nnsa_pkg::DATA_W-1:0] pwdata,
	input  logic                        drained,
	output int                          fail_count,
	output int                          checked,
	output int                          depth_seen,
	output int                          range_seen
);
	import nnsa_pkg::*;

	localparam longint unsigned BITS_PER_BYTE = 8;
	localparam int REPORT_LIMIT = 40;

	typedef struct packed {
		logic [OFF_W-1:0] src_off;
		logic [OFF_W-1:0] dst_off;
		logic [PB_W-1:0]  pix_bytes;
		logic [ST_W-1:0]  st;
	} pixel_addr_t;

	// register contents exactly as written, before any clamping
	typedef struct packed {
		logic [DIM_W-1:0]  sw, sh, dw, dh;
		logic [LINE_W-1:0] sl, dl;
		logic [BPP_W-1:0]  sbpp, dbpp;
	} frame_regs_t;

	frame_regs_t frame;
	pixel_addr_t pending_addrs[$];
	pixel_addr_t want;
	int n_fail;
	int n_checked;
	int n_depth;
	int n_range;
	logic leftovers_done;

	function automatic longint unsigned clamp_to(longint unsigned v, longint unsigned top);
		return (v > top) ? top : v;
	endfunction

	function automatic pixel_addr_t map_pixel(frame_regs_t f, logic [COL_W-1:0] c,
			logic [COL_W-1:0] r);
		longint unsigned sw, sh, dw, dh, sl, dl, pb, scol, srow;
		pixel_addr_t res;
		res = '0;
		sw = clamp_to(f.sw, MAX_DIM);
		sh = clamp_to(f.sh, MAX_DIM);
		dw = clamp_to(f.dw, MAX_DIM);
		dh = clamp_to(f.dh, MAX_DIM);
		sl = clamp_to(f.sl, MAX_LINE_BYTES);
		dl = clamp_to(f.dl, MAX_LINE_BYTES);
		// depth check wins over the coordinate check
		if (f.sbpp != f.dbpp) begin
			res.st = ST_DEPTH;
		end else if (c >= dw || r >= dh) begin
			// also covers a zero destination size, so no divide by zero below
			res.st = ST_RANGE;
		end else begin
			pb = f.sbpp / BITS_PER_BYTE;
			scol = c * sw / dw;
			srow = r * sh / dh;
			res.src_off = OFF_W'(srow * sl + scol * pb);
			res.dst_off = OFF_W'(r * dl + c * pb);
			res.pix_bytes = PB_W'(pb);
			res.st = ST_OK;
		end
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		if (n_fail < REPORT_LIMIT)
			$display("%0t: mismatch: %s", $time, msg);
		n_fail++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame = '{sw: 1, sh: 1, dw: 1, dh: 1, sl: 1, dl: 1, sbpp: 8, dbpp: 8};
			pending_addrs.delete();
			n_fail = 0;
			n_checked = 0;
			n_depth = 0;
			n_range = 0;
			leftovers_done = 1'b0;
		end else begin
			// results first: an item taken at this edge cannot leave at it
			if (out_valid && out_ready) begin
				if (pending_addrs.size() == 0) begin
					report_mismatch($sformatf("result transfer with nothing pending (status %0d)",
						status));
				end else begin
					want = pending_addrs.pop_front();
					n_checked++;
					if (src_offset !== want.src_off)
						report_mismatch($sformatf("src_offset got %0d want %0d",
							src_offset, want.src_off));
					if (dst_offset !== want.dst_off)
						report_mismatch($sformatf("dst_offset got %0d want %0d",
							dst_offset, want.dst_off));
					if (pixel_bytes !== want.pix_bytes)
						report_mismatch($sformatf("pixel_bytes got %0d want %0d",
							pixel_bytes, want.pix_bytes));
					if (status !== want.st)
						report_mismatch($sformatf("status got %0d want %0d", status, want.st));
				end
			end
			if (in_valid && in_ready) begin
				want = map_pixel(frame, dest_col, dest_row);
				pending_addrs.push_back(want);
				if (want.st == ST_DEPTH)
					n_depth++;
				if (want.st == ST_RANGE)
					n_range++;
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_SRC_WIDTH:  frame.sw = pwdata[DIM_W-1:0];
					REG_SRC_HEIGHT: frame.sh = pwdata[DIM_W-1:0];
					REG_DST_WIDTH:  frame.dw = pwdata[DIM_W-1:0];
					REG_DST_HEIGHT: frame.dh = pwdata[DIM_W-1:0];
					REG_SRC_LINE:   frame.sl = pwdata[LINE_W-1:0];
					REG_DST_LINE:   frame.dl = pwdata[LINE_W-1:0];
					REG_SRC_BPP:    frame.sbpp = pwdata[BPP_W-1:0];
					REG_DST_BPP:    frame.dbpp = pwdata[BPP_W-1:0];
					default: ;
				endcase
			end
			if (drained && !leftovers_done) begin
				leftovers_done = 1'b1;
				if (pending_addrs.size() != 0)
					report_mismatch($sformatf("%0d results never arrived", pending_addrs.size()));
			end
		end
		fail_count <= n_fail;
		checked <= n_checked;
		depth_seen <= n_depth;
		range_seen <= n_range;
	end

endmodule

/* tb/nearest_neighbor_scale_address_unit_tb.sv */
`timescale 1ns / 100ps
// stimulus, register setup and verdict for the nearest-neighbor scale address unit
module nearest_neighbor_scale_address_unit_tb;
	import nnsa_pkg::*;

	localparam int CLK_PERIOD = 4;
	localparam int RESET_CYCLES = 11;
	localparam int RAND_PHASES = 24;
	localparam int ITEMS_PER_PHASE = 68;
	localparam int PRESSURE_PHASE = 4;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int LIMIT_CYCLES = 200000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [COL_W-1:0]  dest_col = '0;
	logic [COL_W-1:0]  dest_row = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [OFF_W-1:0]  src_offset;
	logic [OFF_W-1:0]  dst_offset;
	logic [PB_W-1:0]   pixel_bytes;
	logic [ST_W-1:0]   status;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	logic drained = 1'b0;
	logic hold_go = 1'b0;
	int   stall_pct = 0;
	int   send_idle = 0;
	int   hold_left = 0;
	int   sent = 0;
	int   settings = 1;
	int   frame_w = 1;
	int   frame_h = 1;
	int   fail_count;
	int   checked;
	int   depth_seen;
	int   range_seen;

	nearest_neighbor_scale_address_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.dest_col    (dest_col),
		.dest_row    (dest_row),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.src_offset  (src_offset),
		.dst_offset  (dst_offset),
		.pixel_bytes (pixel_bytes),
		.status      (status),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	scale_address_checker scale_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.dest_col    (dest_col),
		.dest_row    (dest_row),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.src_offset  (src_offset),
		.dst_offset  (dst_offset),
		.pixel_bytes (pixel_bytes),
		.status      (status),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.drained     (drained),
		.fail_count  (fail_count),
		.checked     (checked),
		.depth_seen  (depth_seen),
		.range_seen  (range_seen)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("timeout: %0d of %0d results seen", checked, sent);
		$display("== FAIL ==");
		$finish;
	end

	// result side: random stalls, plus one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (hold_go)
				hold_left = HOLD_CYCLES;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic write_reg(input reg_idx_t idx, input int unsigned val);
		int w;
		case (idx) inside
			REG_SRC_LINE, REG_DST_LINE: w = LINE_W;
			REG_SRC_BPP, REG_DST_BPP:   w = BPP_W;
			default:                    w = DIM_W;
		endcase
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		// junk above the field width must be dropped by the register
		pwdata <= ($urandom << w) | (val & ((32'd1 << w) - 32'd1));
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
	endtask

	task automatic set_frame(input int unsigned sw, sh, dw, dh, sl, dl, sbpp, dbpp);
		in_valid <= 1'b0;
		while (checked != sent) @(posedge clk);
		write_reg(REG_SRC_WIDTH, sw);
		write_reg(REG_SRC_HEIGHT, sh);
		write_reg(REG_DST_WIDTH, dw);
		write_reg(REG_DST_HEIGHT, dh);
		write_reg(REG_SRC_LINE, sl);
		write_reg(REG_DST_LINE, dl);
		write_reg(REG_SRC_BPP, sbpp);
		write_reg(REG_DST_BPP, dbpp);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		frame_w = (dw > MAX_DIM) ? MAX_DIM : dw;
		frame_h = (dh > MAX_DIM) ? MAX_DIM : dh;
		settings++;
	endtask

	task automatic send_coord(input int c, input int r);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		dest_col <= COL_W'(c);
		dest_row <= COL_W'(r);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	function automatic int pick_dim();
		return $urandom_range(1) ? $urandom_range(1, 64) : $urandom_range(1, MAX_DIM);
	endfunction

	task automatic random_frame();
		int unsigned bpp;
		if ($urandom_range(99) < 75) begin
			bpp = 8 * $urandom_range(1, 4);
			set_frame(pick_dim(), pick_dim(), pick_dim(), pick_dim(),
				$urandom_range(1, MAX_LINE_BYTES), $urandom_range(1, MAX_LINE_BYTES), bpp, bpp);
		end else begin
			// raw register contents: zeros, oversized values, odd or mismatched depths
			bpp = $urandom_range(63);
			set_frame($urandom_range(8191), $urandom_range(8191), $urandom_range(8191),
				$urandom_range(8191), $urandom_range(32767), $urandom_range(32767),
				bpp, $urandom_range(1) ? bpp : $urandom_range(63));
		end
	endtask

	task automatic send_random(input int n);
		int c, r;
		repeat (n) begin
			if (frame_w > 0 && frame_h > 0 && $urandom_range(99) < 85) begin
				c = $urandom_range(frame_w - 1);
				r = $urandom_range(frame_h - 1);
			end else begin
				c = $urandom;
				r = $urandom;
			end
			send_coord(c, r);
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// settings after reset: unit scale, one byte per pixel
		send_coord(0, 0);
		send_coord(4095, 4095);
		send_coord(0, 1);
		// largest legal frame, deepest legal pixels
		set_frame(4096, 4096, 4096, 4096, 16384, 16384, 32, 32);
		send_coord(4095, 4095);
		send_coord(0, 4095);
		send_coord(4095, 0);
		send_coord(0, 0);
		// oversized registers get clamped, source offset wraps
		set_frame(8191, 8191, 8191, 5000, 32767, 32767, 63, 63);
		send_coord(4095, 4095);
		send_coord(2048, 100);
		// empty source picks column and row 0, depth below a byte
		set_frame(0, 0, 100, 50, 1000, 300, 7, 7);
		send_coord(99, 49);
		send_coord(10, 10);
		// empty destination, every coordinate is outside
		set_frame(64, 64, 0, 0, 64, 64, 56, 56);
		send_coord(0, 0);
		send_coord(5, 5);
		// depth mismatch is flagged even for an outside coordinate
		set_frame(320, 240, 320, 240, 960, 960, 16, 24);
		send_coord(4095, 4095);
		send_coord(0, 0);
		// upscale
		set_frame(640, 480, 1920, 1080, 1920, 5760, 24, 24);
		send_coord(1919, 1079);
		send_coord(960, 540);
		send_coord(1, 1);
		send_coord(1920, 0);

		for (int p = 0; p < RAND_PHASES; p++) begin
			random_frame();
			case (p % 4)
				0: begin
					send_idle = 0;
					stall_pct <= 0;
				end
				1: begin
					send_idle = 49;
					stall_pct <= 0;
				end
				2: begin
					send_idle = 0;
					stall_pct <= 49;
				end
				default: begin
					send_idle = 19;
					stall_pct <= 19;
				end
			endcase
			if (p == PRESSURE_PHASE) begin
				// output held off while input keeps coming, pipeline fills up
				hold_go <= 1'b1;
				@(posedge clk);
				hold_go <= 1'b0;
			end
			send_random(ITEMS_PER_PHASE);
		end
		in_valid <= 1'b0;

		while (checked != sent) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		drained <= 1'b1;
		repeat (2) @(posedge clk);

		$display("%0d coordinates under %0d register settings, %0d results checked",
			sent, settings, checked);
		$display("%0d depth mismatches, %0d outside destination, one %0d-cycle output hold-off",
			depth_seen, range_seen, HOLD_CYCLES);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* filelist.f */
src/nnsa_pkg.sv
src/nnsa_cfg_regs.sv
src/nnsa_div_pipe.sv
src/nearest_neighbor_scale_address_unit.sv
tb/scale_address_checker.sv
tb/nearest_neighbor_scale_address_unit_tb.sv
